// ===== hw/rtl/arpc_pkg.sv =====
// Shared constants, command codes and the queued transaction type of the ARP cache table.
package arpc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int CMD_W  = 2;
  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int TICK_W = 32;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  // Register addresses on the APB port
  localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT = 2'd0;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd60000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 2'd2;

  // Operation class handed from front to back
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_REVERSE,
    OP_NONE
  } op_t;

  // Classified transaction; a lookup already carries its miss-entry data
  typedef struct packed {
    op_t               op;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TICK_W-1:0] stamp;
    logic [TICK_W-1:0] now;
  } item_t;

endpackage

// ===== hw/rtl/arpc_if.sv =====
// Valid/ready channel interfaces for ARP cache commands and results.
interface arpc_in_if;
  logic                         valid;
  logic                         ready;
  logic [arpc_pkg::CMD_W-1:0]   cmd;
  logic [arpc_pkg::IP_W-1:0]    ip_addr;
  logic [arpc_pkg::MAC_W-1:0]   mac_addr;
  logic [arpc_pkg::TICK_W-1:0]  entry_stamp;
  logic [arpc_pkg::TICK_W-1:0]  now_ticks;

  modport source (output valid, cmd, ip_addr, mac_addr, entry_stamp, now_ticks,
                  input ready);
  modport sink (input valid, cmd, ip_addr, mac_addr, entry_stamp, now_ticks,
                output ready);
endinterface

interface arpc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [arpc_pkg::MAC_W-1:0] mac_result;
  logic [arpc_pkg::IP_W-1:0]  ip_result;
  logic                       query_request;
  logic                       insert_dropped;

  modport source (output valid, found, mac_result, ip_result, query_request,
                  insert_dropped, input ready);
  modport sink (input valid, found, mac_result, ip_result, query_request,
                insert_dropped, output ready);
endinterface

// ===== hw/rtl/arpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write then register the read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/arpc_front.sv =====
// Front stage: accept command transactions and classify them for the back end.
module arpc_front (
  input  logic              clk,
  input  logic              rst,
  arpc_in_if.sink           in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output arpc_pkg::item_t   push_item
);

  logic            stage_valid;
  arpc_pkg::item_t stage;
  arpc_pkg::item_t cls;

  assign in_ch.ready = !stage_valid || push_ready;
  assign push_valid  = stage_valid;
  assign push_item   = stage;

  // Classify the command; a lookup carries a zero MAC and the current time for a miss entry
  always_comb begin
    cls.ip    = in_ch.ip_addr;
    cls.mac   = in_ch.mac_addr;
    cls.stamp = in_ch.entry_stamp;
    cls.now   = in_ch.now_ticks;
    unique case (in_ch.cmd)
      arpc_pkg::CMD_INSERT: begin
        cls.op = arpc_pkg::OP_INSERT;
      end
      arpc_pkg::CMD_LOOKUP: begin
        cls.op    = arpc_pkg::OP_LOOKUP;
        cls.mac   = '0;
        cls.stamp = in_ch.now_ticks;
      end
      arpc_pkg::CMD_REVERSE: begin
        cls.op = arpc_pkg::OP_REVERSE;
      end
      default: begin
        cls.op = arpc_pkg::OP_NONE;
      end
    endcase
  end

  // Hold the stage until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage <= cls;
    end
  end

endmodule

// ===== hw/rtl/arpc_queue.sv =====
// Short FIFO of classified transactions between front and back.
module arpc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  arpc_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output arpc_pkg::item_t pop_item
);

  arpc_pkg::item_t                 mem [arpc_pkg::QUEUE_DEPTH];
  logic [arpc_pkg::QPTR_W-1:0]     wr_ptr;
  logic [arpc_pkg::QPTR_W-1:0]     rd_ptr;
  logic [arpc_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = count != arpc_pkg::QCNT_W'(arpc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers with wrap and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == arpc_pkg::QPTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == arpc_pkg::QPTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/arpc_back.sv =====
// Back end: scan the slot RAMs for one transaction, then update the table and post the result.
module arpc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [arpc_pkg::TICK_W-1:0]  timeout_ticks,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  arpc_pkg::item_t              pop_item,
  arpc_out_if.source                   out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  arpc_pkg::item_t cur;

  logic [arpc_pkg::CNT_W-1:0] cnt;
  logic                       rd_live;
  logic [arpc_pkg::IDX_W-1:0] proc_idx;

  logic [arpc_pkg::IP_W-1:0]   rd_ip;
  logic [arpc_pkg::MAC_W-1:0]  rd_mac;
  logic [arpc_pkg::TICK_W-1:0] rd_stamp;

  logic [arpc_pkg::ENTRIES-1:0] slot_valid;
  logic [arpc_pkg::ENTRIES-1:0] slot_valid_next;
  logic [arpc_pkg::ENTRIES-1:0] expire;

  // Scan results
  logic                        ip_hit;
  logic [arpc_pkg::IDX_W-1:0]  ip_idx;
  logic                        ip_nz;
  logic [arpc_pkg::MAC_W-1:0]  hit_mac;
  logic                        mac_hit;
  logic [arpc_pkg::IDX_W-1:0]  mac_idx;
  logic                        mac_nz;
  logic [arpc_pkg::IP_W-1:0]   hit_ip;
  logic                        free_hit;
  logic [arpc_pkg::IDX_W-1:0]  free_idx;
  logic                        old_hit;
  logic [arpc_pkg::IDX_W-1:0]  old_idx;
  logic [arpc_pkg::TICK_W-1:0] old_stamp;

  // Per-entry evaluation
  logic ent_valid;
  logic ent_nz;
  logic ip_match;
  logic mac_match;
  logic free_seen;
  logic older;
  logic ent_aged;

  // Commit decisions
  logic                        out_free;
  logic                        start;
  logic                        commit_fire;
  logic                        can_store;
  logic                        new_aged;
  logic [arpc_pkg::IDX_W-1:0]  target;
  logic                        we_ip;
  logic                        we_mac;
  logic                        we_stamp;
  logic [arpc_pkg::IDX_W-1:0]  wr_idx;
  logic [arpc_pkg::TICK_W-1:0] wr_stamp;
  logic                        res_found;
  logic [arpc_pkg::MAC_W-1:0]  res_mac;
  logic [arpc_pkg::IP_W-1:0]   res_ip;
  logic                        res_query;
  logic                        res_dropped;

  // Output register
  logic                        out_valid;
  logic                        out_found;
  logic [arpc_pkg::MAC_W-1:0]  out_mac;
  logic [arpc_pkg::IP_W-1:0]   out_ip;
  logic                        out_query;
  logic                        out_dropped;

  function automatic logic aged(input logic [arpc_pkg::TICK_W-1:0] stamp,
                                input logic [arpc_pkg::TICK_W-1:0] tmo,
                                input logic [arpc_pkg::TICK_W-1:0] now);
    logic [arpc_pkg::TICK_W:0] sum;
    sum = {1'b0, stamp} + {1'b0, tmo};
    return sum <= {1'b0, now};
  endfunction

  assign pop_ready   = state == ST_IDLE;
  assign start       = pop_valid && pop_ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign commit_fire = (state == ST_COMMIT) && out_free;

  // Slot storage, read in address order during the scan
  arpc_ram #(.WIDTH(arpc_pkg::IP_W), .DEPTH(arpc_pkg::ENTRIES)) u_ip_ram (
    .clk   (clk),
    .we    (commit_fire && we_ip),
    .waddr (wr_idx),
    .wdata (cur.ip),
    .raddr (cnt[arpc_pkg::IDX_W-1:0]),
    .rdata (rd_ip)
  );

  arpc_ram #(.WIDTH(arpc_pkg::MAC_W), .DEPTH(arpc_pkg::ENTRIES)) u_mac_ram (
    .clk   (clk),
    .we    (commit_fire && we_mac),
    .waddr (wr_idx),
    .wdata (cur.mac),
    .raddr (cnt[arpc_pkg::IDX_W-1:0]),
    .rdata (rd_mac)
  );

  arpc_ram #(.WIDTH(arpc_pkg::TICK_W), .DEPTH(arpc_pkg::ENTRIES)) u_stamp_ram (
    .clk   (clk),
    .we    (commit_fire && we_stamp),
    .waddr (wr_idx),
    .wdata (wr_stamp),
    .raddr (cnt[arpc_pkg::IDX_W-1:0]),
    .rdata (rd_stamp)
  );

  // Evaluate the entry whose read data just arrived
  always_comb begin
    ent_valid = slot_valid[proc_idx];
    ent_nz    = rd_stamp != '0;
    ip_match  = rd_live && ent_valid && (rd_ip == cur.ip);
    mac_match = rd_live && ent_valid && (rd_mac == cur.mac);
    free_seen = rd_live && !ent_valid;
    older     = rd_live && ent_valid && ent_nz && (!old_hit || (rd_stamp < old_stamp));
    ent_aged  = rd_live && ent_valid && ent_nz && aged(rd_stamp, timeout_ticks, cur.now);
  end

  // Sequence: take a transaction, scan all slots, then commit
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == arpc_pkg::CNT_W'(arpc_pkg::ENTRIES)) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      rd_live <= 1'b0;
    end else begin
      state   <= state_next;
      rd_live <= (state == ST_SCAN) && (cnt != arpc_pkg::CNT_W'(arpc_pkg::ENTRIES));
      if (start) begin
        cnt <= '0;
      end else if ((state == ST_SCAN) && (cnt != arpc_pkg::CNT_W'(arpc_pkg::ENTRIES))) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Latch the transaction and the index of the entry in flight
  always_ff @(posedge clk) begin
    if (start) begin
      cur <= pop_item;
    end
    proc_idx <= cnt[arpc_pkg::IDX_W-1:0];
    if (rd_live) begin
      expire[proc_idx] <= ent_aged;
    end
  end

  // Track first matches, first free slot and oldest aging entry
  always_ff @(posedge clk) begin
    if (rst || start) begin
      ip_hit   <= 1'b0;
      mac_hit  <= 1'b0;
      free_hit <= 1'b0;
      old_hit  <= 1'b0;
    end else begin
      if (ip_match && !ip_hit) begin
        ip_hit <= 1'b1;
      end
      if (mac_match && !mac_hit) begin
        mac_hit <= 1'b1;
      end
      if (free_seen && !free_hit) begin
        free_hit <= 1'b1;
      end
      if (older) begin
        old_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ip_match && !ip_hit) begin
      ip_idx  <= proc_idx;
      ip_nz   <= ent_nz;
      hit_mac <= rd_mac;
    end
    if (mac_match && !mac_hit) begin
      mac_idx <= proc_idx;
      mac_nz  <= ent_nz;
      hit_ip  <= rd_ip;
    end
    if (free_seen && !free_hit) begin
      free_idx <= proc_idx;
    end
    if (older) begin
      old_idx   <= proc_idx;
      old_stamp <= rd_stamp;
    end
  end

  // Decide table writes, valid update and the result
  always_comb begin
    can_store       = free_hit || old_hit;
    target          = free_hit ? free_idx : old_idx;
    new_aged        = (cur.stamp != '0) && aged(cur.stamp, timeout_ticks, cur.now);
    we_ip           = 1'b0;
    we_mac          = 1'b0;
    we_stamp        = 1'b0;
    wr_idx          = ip_idx;
    wr_stamp        = cur.now;
    slot_valid_next = slot_valid;
    res_found       = 1'b0;
    res_mac         = '0;
    res_ip          = '0;
    res_query       = 1'b0;
    res_dropped     = 1'b0;
    unique case (cur.op)
      arpc_pkg::OP_INSERT, arpc_pkg::OP_LOOKUP: begin
        if (ip_hit) begin
          if (cur.op == arpc_pkg::OP_INSERT) begin
            we_mac   = 1'b1;
            we_stamp = 1'b1;
            wr_stamp = cur.stamp;
          end else begin
            res_found = 1'b1;
            res_mac   = hit_mac;
            we_stamp  = ip_nz;
          end
        end else begin
          // New entry, then purge aged entries including the one just stored
          res_query   = cur.op == arpc_pkg::OP_LOOKUP;
          res_dropped = !can_store;
          wr_idx      = target;
          wr_stamp    = cur.stamp;
          we_ip       = can_store;
          we_mac      = can_store;
          we_stamp    = can_store;
          for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
            if (can_store && (target == arpc_pkg::IDX_W'(i))) begin
              slot_valid_next[i] = !new_aged;
            end else begin
              slot_valid_next[i] = slot_valid[i] && !expire[i];
            end
          end
        end
      end
      arpc_pkg::OP_REVERSE: begin
        if (mac_hit) begin
          res_found = 1'b1;
          res_ip    = hit_ip;
          we_stamp  = mac_nz;
          wr_idx    = mac_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // Apply the valid update and post the result
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else if (commit_fire) begin
      slot_valid <= slot_valid_next;
      out_valid  <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_fire) begin
      out_found   <= res_found;
      out_mac     <= res_mac;
      out_ip      <= res_ip;
      out_query   <= res_query;
      out_dropped <= res_dropped;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.found          = out_found;
  assign out_ch.mac_result     = out_mac;
  assign out_ch.ip_result      = out_ip;
  assign out_ch.query_request  = out_query;
  assign out_ch.insert_dropped = out_dropped;

endmodule

// ===== hw/rtl/arp_cache_table_core.sv =====
// Top level of the ARP cache table: APB timeout register, front stage, queue and back end.
// Path from command acceptance to result valid: front stage, queue, slot scan, commit, output register.
// The back end takes no new transaction until it has scanned every slot through the
//   single read port of the slot RAMs and committed the last one.
// Reset: all slots invalid at once, timeout 60000 ticks; no clearing pass is needed.
module arp_cache_table_core (
  input  logic                             clk,
  input  logic                             rst,
  arpc_in_if.sink                          in_ch,
  arpc_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [arpc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [arpc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [arpc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  logic [arpc_pkg::TICK_W-1:0] timeout_ticks;
  logic                        push_valid;
  logic                        push_ready;
  arpc_pkg::item_t             push_item;
  logic                        pop_valid;
  logic                        pop_ready;
  arpc_pkg::item_t             pop_item;
  logic                        reg_sel;

  // Decode the single timeout register
  assign reg_sel = paddr == arpc_pkg::ADDR_TIMEOUT;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? timeout_ticks : '0;

  // Write the timeout register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= arpc_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      timeout_ticks <= pwdata[arpc_pkg::TICK_W-1:0];
    end
  end

  arpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  arpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  arpc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .timeout_ticks (timeout_ticks),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .out_ch        (out_ch)
  );

endmodule
